FILE: design/ortl_pkg.sv
// Shared types and constants of the overwrite ring trace log.
// No dependencies; imported by ortl_front, ortl_back and the top level.
`default_nettype none
package ortl_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int DATA_BITS_DEF = 32;

	localparam int CAP_BITS   = 5;
	localparam int WORD_BITS  = 32;
	localparam int SRC_BITS   = 8;
	localparam int MAXE_BITS  = 5;
	localparam int KIND_BITS  = 2;
	localparam int IN_TDATA_BITS  = 80;
	localparam int OUT_TDATA_BITS = 112;

	localparam logic FUNC_APPEND   = 1'b0;
	localparam logic FUNC_SNAPSHOT = 1'b1;

	localparam logic [KIND_BITS-1:0] KIND_ACK   = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_ENTRY = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_EMPTY = 2'd2;

	typedef struct packed {
		logic                 func;
		logic [WORD_BITS-1:0] payload;
		logic [SRC_BITS-1:0]  source_id;
		logic [WORD_BITS-1:0] time_stamp;
		logic [MAXE_BITS-1:0] snap_limit;
	} cmd_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [WORD_BITS-1:0] seq_number;
		logic [SRC_BITS-1:0]  entry_source;
		logic [WORD_BITS-1:0] entry_time;
		logic [WORD_BITS-1:0] entry_data;
		logic [MAXE_BITS-1:0] copied_total;
		logic                 last;
	} res_t;

endpackage
`default_nettype wire

FILE: design/ortl_front.sv
// Front end of the trace log: accepts input words and holds them in a two-entry queue.
// Depends on ortl_pkg.
`default_nettype none
module ortl_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire ortl_pkg::cmd_t in_cmd,
	output      logic          cmd_valid,
	input  wire logic          cmd_ready,
	output      ortl_pkg::cmd_t cmd
);
	import ortl_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule
`default_nettype wire

FILE: design/ortl_back.sv
// Back end of the trace log: ring store, pointers, sequence counter and output register.
// Depends on ortl_pkg.
`default_nettype none
module ortl_back #(
	parameter int DEPTH     = ortl_pkg::DEPTH_DEF,
	parameter int DATA_BITS = ortl_pkg::DATA_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [ortl_pkg::CAP_BITS-1:0] cfg_value,
	input  wire logic                          cmd_valid,
	output      logic                          cmd_ready,
	input  wire ortl_pkg::cmd_t                cmd,
	output      logic                          res_valid,
	input  wire logic                          res_ready,
	output      ortl_pkg::res_t                res
);
	import ortl_pkg::*;

	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = ($clog2(DEPTH + 1) > CAP_BITS) ? $clog2(DEPTH + 1) : CAP_BITS;
	localparam int LW  = (PW + 1 > CW) ? PW + 1 : CW;
	localparam int EW  = WORD_BITS + SRC_BITS + WORD_BITS + DATA_BITS;
	localparam int T_LO = DATA_BITS;
	localparam int S_LO = DATA_BITS + WORD_BITS;
	localparam int Q_LO = DATA_BITS + WORD_BITS + SRC_BITS;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t                 state_q;
	logic [PW-1:0]          wptr_q;
	logic [PW-1:0]          optr_q;
	logic [PW-1:0]          rptr_q;
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          cap_q;
	logic [WORD_BITS-1:0]   seq_q;
	logic [MAXE_BITS-1:0]   total_q;
	logic [MAXE_BITS-1:0]   idx_q;
	logic                   out_valid_q;
	res_t                   out_q;
	logic [EW-1:0]          mem_q [DEPTH];
	logic [EW-1:0]          rdata_q;

	logic                   out_free;
	logic                   pop;
	logic                   out_load;
	logic [MAXE_BITS-1:0]   n_cmd;
	logic                   final_now;
	logic                   wr_en;
	logic                   rd_en;
	logic [PW-1:0]          rd_addr;
	logic [CW-1:0]          cap_new;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p,
			input logic [CW-1:0] cap);
		logic [PW:0] n1;
		begin
			n1 = {1'b0, p} + (PW + 1)'(1);
			ring_next = (LW'(n1) >= LW'(cap)) ? '0 : PW'(n1);
		end
	endfunction

	assign out_free  = !out_valid_q || res_ready;
	assign cmd_ready = (state_q == ST_IDLE) && out_free && !cfg_write;
	assign pop       = cmd_valid && cmd_ready;
	assign n_cmd     = (CW'(cmd.snap_limit) < fill_q) ? cmd.snap_limit
		: MAXE_BITS'(fill_q);
	assign final_now = (idx_q + MAXE_BITS'(1)) == total_q;
	assign out_load  = (pop && ((cmd.func == FUNC_APPEND) || (n_cmd == '0)))
		|| ((state_q == ST_EMIT) && out_free);
	assign wr_en     = pop && (cmd.func == FUNC_APPEND);
	assign rd_en     = (pop && (cmd.func == FUNC_SNAPSHOT) && (n_cmd != '0))
		|| ((state_q == ST_EMIT) && out_free && !final_now);
	assign rd_addr   = (state_q == ST_IDLE) ? optr_q : rptr_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		cap_new = CW'(cfg_value);
		if (cap_new == '0) begin
			cap_new = CW'(1);
		end else if (cap_new > CW'(DEPTH)) begin
			cap_new = CW'(DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wptr_q      <= '0;
			optr_q      <= '0;
			rptr_q      <= '0;
			fill_q      <= '0;
			cap_q       <= CW'(DEPTH);
			seq_q       <= WORD_BITS'(1);
			total_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				cap_q  <= cap_new;
				wptr_q <= '0;
				optr_q <= '0;
				fill_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (cmd.func == FUNC_APPEND) begin
							seq_q       <= seq_q + WORD_BITS'(1);
							wptr_q      <= ring_next(wptr_q, cap_q);
							if (fill_q < cap_q) begin
								fill_q <= fill_q + CW'(1);
							end else begin
								optr_q <= ring_next(optr_q, cap_q);
							end
						end else if (n_cmd != '0) begin
							rptr_q  <= ring_next(optr_q, cap_q);
							total_q <= n_cmd;
							idx_q   <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (final_now) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q  <= idx_q + MAXE_BITS'(1);
							rptr_q <= ring_next(rptr_q, cap_q);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && pop) begin
			out_q <= '{
				kind:         (cmd.func == FUNC_APPEND) ? KIND_ACK : KIND_EMPTY,
				seq_number:   (cmd.func == FUNC_APPEND) ? seq_q : WORD_BITS'(0),
				entry_source: SRC_BITS'(0),
				entry_time:   WORD_BITS'(0),
				entry_data:   WORD_BITS'(0),
				copied_total: MAXE_BITS'(0),
				last:         1'b1
			};
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_q <= '{
				kind:         KIND_ENTRY,
				seq_number:   rdata_q[Q_LO +: WORD_BITS],
				entry_source: rdata_q[S_LO +: SRC_BITS],
				entry_time:   rdata_q[T_LO +: WORD_BITS],
				entry_data:   WORD_BITS'(rdata_q[DATA_BITS-1:0]),
				copied_total: total_q,
				last:         final_now
			};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= {seq_q, cmd.source_id, cmd.time_stamp,
				DATA_BITS'(cmd.payload)};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: design/overwrite_ring_trace_log_top.sv
// Top level of the overwrite ring trace log: stream ports, front queue and back end.
// Depends on ortl_pkg, ortl_front and ortl_back.
//
// Input words on s_axis: tuser selects append (0) or snapshot (1). An append
// stores payload, source id and time stamp at the head of the ring and is
// answered by one word of kind 0 carrying its sequence number. A snapshot
// returns up to snap_limit stored entries oldest first, one word each, tlast on the final
// one; with nothing to return it gives one word of kind 2.
// An append answer or an empty snapshot word passes the input queue and the
// output register; snapshot entries also pass the registered ring read, one
// entry per cycle while m_axis does not stall.
// Appends run at one per cycle while m_axis does not stall and no cfg write comes;
// the back end takes no new input word until a snapshot has loaded its final entry.
// The cfg channel takes the ring capacity (0 counts as 1, above DEPTH as
// DEPTH) and empties the log; the sequence counter is kept.
// Reset empties the log, sets capacity to DEPTH and the next number to 1; no
// clearing pass. When m_axis stalls, the output register holds its word and
// the two-entry input queue keeps taking words until full.
`default_nettype none
module overwrite_ring_trace_log_top #(
	parameter int DEPTH     = ortl_pkg::DEPTH_DEF,
	parameter int DATA_BITS = ortl_pkg::DATA_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [ortl_pkg::CAP_BITS-1:0]       cfg_data,
	input  wire logic                                s_axis_tvalid,
	output      logic                                s_axis_tready,
	// payload[31:0], source_id[39:32], time_stamp[71:40], snap_limit[76:72]
	input  wire logic [ortl_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
	// func[0]
	input  wire logic                                s_axis_tuser,
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// seq_number[31:0], entry_source[39:32], entry_time[71:40],
	// entry_data[103:72], copied_total[108:104]
	output      logic [ortl_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
	// kind[1:0]
	output      logic [ortl_pkg::KIND_BITS-1:0]      m_axis_tuser,
	output      logic                                m_axis_tlast
);
	import ortl_pkg::*;

	cmd_t in_cmd;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;
	res_t res;

	assign cfg_ready = 1'b1;

	assign in_cmd = {s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32],
		s_axis_tdata[71:40], s_axis_tdata[76:72]};

	assign m_axis_tdata = {3'b000, res.copied_total, res.entry_data, res.entry_time,
		res.entry_source, res.seq_number};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

	ortl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (in_cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	ortl_back #(
		.DEPTH     (DEPTH),
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_value (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

endmodule
`default_nettype wire
